// ===== rtl/bprl_pkg.sv =====
// shared types, codes and tag name tables for the batch request list parser
`default_nettype none

package bprl_pkg;

   // result event codes
   localparam logic [2:0] EV_NONE         = 3'd0;
   localparam logic [2:0] EV_METHOD_BEGIN = 3'd1;
   localparam logic [2:0] EV_METHOD_CHAR  = 3'd2;
   localparam logic [2:0] EV_URL_BEGIN    = 3'd3;
   localparam logic [2:0] EV_URL_CHAR     = 3'd4;
   localparam logic [2:0] EV_ENTRY_DONE   = 3'd5;
   localparam logic [2:0] EV_BATCH_OK     = 3'd6;
   localparam logic [2:0] EV_ERROR        = 3'd7;

   // error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_UNEXPECTED = 3'd1;
   localparam logic [2:0] ERR_MISSING    = 3'd2;
   localparam logic [2:0] ERR_UNCLOSED   = 3'd3;
   localparam logic [2:0] ERR_NOT_CLOSED = 3'd4;

   // value targets
   localparam logic [1:0] TGT_NONE   = 2'd0;
   localparam logic [1:0] TGT_METHOD = 2'd1;
   localparam logic [1:0] TGT_URL    = 2'd2;

   // grammar characters
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_RBRACKET  = 8'h5D;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;

   // tag name lengths and saturation limit
   localparam logic [3:0] METHOD_LEN = 4'd6;
   localparam logic [3:0] URL_LEN    = 4'd12;
   localparam logic [3:0] TAG_LEN_MAX = 4'd15;

   // default depth of the queue between parser and output side
   localparam int QUEUE_DEPTH_DEF = 4;

   // max results caused by one byte
   localparam int MAX_RES = 3;

   // one result item
   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] char_out;
      logic [2:0] error_code;
   } bprl_result_type;

   // all results of one input byte
   typedef struct packed {
      logic [1:0]                    num_res;
      bprl_result_type [MAX_RES-1:0] res;
   } bprl_bundle_type;

   // "method" by position
   function automatic logic [7:0] method_char(input logic [3:0] idx);
      logic [7:0] ch;
      unique case (idx)
         4'd0:    ch = 8'h6D; // m
         4'd1:    ch = 8'h65; // e
         4'd2:    ch = 8'h74; // t
         4'd3:    ch = 8'h68; // h
         4'd4:    ch = 8'h6F; // o
         4'd5:    ch = 8'h64; // d
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // url tag name by position
   function automatic logic [7:0] url_char(input logic [3:0] idx);
      logic [7:0] ch;
      unique case (idx)
         4'd0:    ch = 8'h72; // r
         4'd1:    ch = 8'h65; // e
         4'd2:    ch = 8'h6C; // l
         4'd3:    ch = 8'h61; // a
         4'd4:    ch = 8'h74; // t
         4'd5:    ch = 8'h69; // i
         4'd6:    ch = 8'h76; // v
         4'd7:    ch = 8'h65; // e
         4'd8:    ch = 8'h5F; // _
         4'd9:    ch = 8'h75; // u
         4'd10:   ch = 8'h72; // r
         4'd11:   ch = 8'h6C; // l
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // build one result item
   function automatic bprl_result_type mk_res(input logic [2:0] ev, input logic [7:0] ch,
                                              input logic [2:0] code);
      bprl_result_type r;
      r.event_res  = ev;
      r.char_out   = ch;
      r.error_code = code;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/batch_request_list_parser_top.sv =====
// top level of the batch request list parser: front, bundle queue and back
//
//   channel  direction  tdata (low bit up)                          tlast
//   req_     in         text_byte[7:0]                              final_byte
//   rsp_     out        event_res[2:0], char_out[10:3],             run_last
//                       error_code[13:11], zero[15:14]
//
// the front takes one byte per cycle whenever the queue has room; a byte
// causes zero to three results. the back sends one result per cycle unless
// rsp_ stalls, so a byte's results leave in turn; the output register is
// the limit when results outnumber bytes. a result passes the queue, then
// the output register. reset is synchronous and empties queue and output
// register. rsp_ stalls fill the queue, after which req_tready drops.
`default_nettype none

module batch_request_list_parser_top
   import bprl_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // text_byte[7:0]
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // event_res[2:0], char_out[10:3], error_code[13:11]
   output logic             rsp_tlast
);

   logic            push_valid;
   bprl_bundle_type push_bundle;
   logic            queue_full;
   logic            queue_empty;
   bprl_bundle_type head;
   logic            pop;
   bprl_result_type out_res;

   // parser front
   bprl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_byte     (req_tdata),
      .in_final    (req_tlast),
      .queue_full  (queue_full),
      .in_ready    (req_tready),
      .push_valid  (push_valid),
      .push_bundle (push_bundle)
   );

   // bundle queue
   bprl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_bundle (push_bundle),
      .pop         (pop),
      .full        (queue_full),
      .empty       (queue_empty),
      .head        (head)
   );

   // output back
   bprl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_res     (out_res),
      .out_last    (rsp_tlast)
   );

   // result packing
   assign rsp_tdata = {2'b00, out_res.error_code, out_res.char_out, out_res.event_res};

endmodule

`default_nettype wire

// ===== rtl/bprl_front.sv =====
// parser front: a byte per cycle unless queue_full; runs grammar, emits result bundles
`default_nettype none

module bprl_front
   import bprl_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire logic [7:0]      in_byte,
   input  wire logic            in_final,
   input  wire logic            queue_full,
   output logic                 in_ready,
   output logic                 push_valid,
   output bprl_bundle_type      push_bundle
);

   // parser phase, one-hot
   typedef enum logic [9:0] {
      PH_START      = 10'b00_0000_0001,
      PH_WANT_BRACE = 10'b00_0000_0010,
      PH_WANT_TAGQ  = 10'b00_0000_0100,
      PH_IN_TAG     = 10'b00_0000_1000,
      PH_WANT_COLON = 10'b00_0001_0000,
      PH_WANT_VALQ  = 10'b00_0010_0000,
      PH_IN_VAL     = 10'b00_0100_0000,
      PH_AFTER_VAL  = 10'b00_1000_0000,
      PH_AFTER_ENT  = 10'b01_0000_0000,
      PH_DONE       = 10'b10_0000_0000
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic       quote_single_ff, quote_single_in;
   logic       escape_ff, escape_in;
   logic [3:0] tag_len_ff, tag_len_in;
   logic       may_method_ff, may_method_in;
   logic       may_url_ff, may_url_in;
   logic [1:0] target_ff, target_in;
   logic       url_first_ff, url_first_in;
   logic       failed_ff, failed_in;

   logic                          accept;
   logic                          blank;
   logic                          expecting;
   logic                          is_quote;
   logic [7:0]                    close_quote;
   logic                          closes;
   logic                          starts_escape;
   bprl_result_type [MAX_RES-1:0] res_bus;
   logic [1:0]                    n_res;

   assign in_ready  = !queue_full;
   assign accept    = in_valid && in_ready;
   assign blank     = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
   assign expecting = (phase_ff != PH_IN_TAG) && (phase_ff != PH_IN_VAL) &&
                      (phase_ff != PH_DONE);
   assign is_quote  = (in_byte == CH_SQUOTE) || (in_byte == CH_DQUOTE);

   // quoted-string byte classification
   assign close_quote   = quote_single_ff ? CH_SQUOTE : CH_DQUOTE;
   assign closes        = !escape_ff && (in_byte == close_quote);
   assign starts_escape = !escape_ff && (in_byte == CH_BACKSLASH);

   // grammar step and result collection
   always_comb begin
      phase_in        = phase_ff;
      quote_single_in = quote_single_ff;
      escape_in       = escape_ff;
      tag_len_in      = tag_len_ff;
      may_method_in   = may_method_ff;
      may_url_in      = may_url_ff;
      target_in       = target_ff;
      url_first_in    = url_first_ff;
      failed_in       = failed_ff;
      res_bus         = '0;
      n_res           = 2'd0;

      if (!failed_ff) begin
         if (expecting && blank) begin
            if (in_final) begin
               res_bus[n_res] = mk_res(EV_ERROR, 8'h00, ERR_MISSING);
               n_res          = n_res + 2'd1;
               failed_in      = 1'b1;
            end
         end else begin
            unique case (phase_ff)
               PH_START: begin
                  if (in_byte == CH_LBRACKET) begin
                     phase_in = PH_WANT_BRACE;
                  end else begin
                     res_bus[n_res] = mk_res(EV_ERROR, 8'h00, ERR_UNEXPECTED);
                     n_res          = n_res + 2'd1;
                     failed_in      = 1'b1;
                  end
               end
               PH_WANT_BRACE: begin
                  if (in_byte == CH_LBRACE) begin
                     phase_in = PH_WANT_TAGQ;
                  end else begin
                     res_bus[n_res] = mk_res(EV_ERROR, 8'h00, ERR_UNEXPECTED);
                     n_res          = n_res + 2'd1;
                     failed_in      = 1'b1;
                  end
               end
               PH_WANT_TAGQ: begin
                  if (is_quote) begin
                     quote_single_in = (in_byte == CH_SQUOTE);
                     escape_in       = 1'b0;
                     tag_len_in      = 4'd0;
                     may_method_in   = 1'b1;
                     may_url_in      = 1'b1;
                     phase_in        = PH_IN_TAG;
                  end else begin
                     res_bus[n_res] = mk_res(EV_ERROR, 8'h00, ERR_UNEXPECTED);
                     n_res          = n_res + 2'd1;
                     failed_in      = 1'b1;
                  end
               end
               PH_IN_TAG: begin
                  if (closes) begin
                     if (may_method_ff && tag_len_ff == METHOD_LEN) begin
                        target_in = TGT_METHOD;
                     end else if (may_url_ff && tag_len_ff == URL_LEN) begin
                        target_in = TGT_URL;
                     end else begin
                        target_in = TGT_NONE;
                     end
                     phase_in = PH_WANT_COLON;
                  end else if (starts_escape) begin
                     escape_in = 1'b1;
                  end else begin
                     // incremental tag match
                     escape_in = 1'b0;
                     if (tag_len_ff >= METHOD_LEN || method_char(tag_len_ff) != in_byte) begin
                        may_method_in = 1'b0;
                     end
                     if (tag_len_ff >= URL_LEN || url_char(tag_len_ff) != in_byte) begin
                        may_url_in = 1'b0;
                     end
                     if (tag_len_ff < TAG_LEN_MAX) begin
                        tag_len_in = tag_len_ff + 4'd1;
                     end
                  end
               end
               PH_WANT_COLON: begin
                  if (in_byte == CH_COLON) begin
                     phase_in = PH_WANT_VALQ;
                  end else begin
                     res_bus[n_res] = mk_res(EV_ERROR, 8'h00, ERR_UNEXPECTED);
                     n_res          = n_res + 2'd1;
                     failed_in      = 1'b1;
                  end
               end
               PH_WANT_VALQ: begin
                  if (is_quote) begin
                     quote_single_in = (in_byte == CH_SQUOTE);
                     escape_in       = 1'b0;
                     phase_in        = PH_IN_VAL;
                     if (target_ff == TGT_METHOD) begin
                        res_bus[n_res] = mk_res(EV_METHOD_BEGIN, 8'h00, ERR_NONE);
                        n_res          = n_res + 2'd1;
                     end else if (target_ff == TGT_URL) begin
                        res_bus[n_res] = mk_res(EV_URL_BEGIN, 8'h00, ERR_NONE);
                        n_res          = n_res + 2'd1;
                        url_first_in   = 1'b1;
                     end
                  end else begin
                     res_bus[n_res] = mk_res(EV_ERROR, 8'h00, ERR_UNEXPECTED);
                     n_res          = n_res + 2'd1;
                     failed_in      = 1'b1;
                  end
               end
               PH_IN_VAL: begin
                  if (closes) begin
                     // empty url value reads as a lone slash
                     if (target_ff == TGT_URL && url_first_ff) begin
                        res_bus[n_res] = mk_res(EV_URL_CHAR, CH_SLASH, ERR_NONE);
                        n_res          = n_res + 2'd1;
                     end
                     url_first_in = 1'b0;
                     phase_in     = PH_AFTER_VAL;
                  end else if (starts_escape) begin
                     escape_in = 1'b1;
                  end else begin
                     escape_in = 1'b0;
                     if (target_ff == TGT_METHOD) begin
                        res_bus[n_res] = mk_res(EV_METHOD_CHAR, in_byte, ERR_NONE);
                        n_res          = n_res + 2'd1;
                     end else if (target_ff == TGT_URL) begin
                        // leading slash when the url lacks one
                        if (url_first_ff) begin
                           url_first_in = 1'b0;
                           if (in_byte != CH_SLASH) begin
                              res_bus[n_res] = mk_res(EV_URL_CHAR, CH_SLASH, ERR_NONE);
                              n_res          = n_res + 2'd1;
                           end
                        end
                        res_bus[n_res] = mk_res(EV_URL_CHAR, in_byte, ERR_NONE);
                        n_res          = n_res + 2'd1;
                     end
                  end
               end
               PH_AFTER_VAL: begin
                  if (in_byte == CH_COMMA) begin
                     phase_in = PH_WANT_TAGQ;
                  end else if (in_byte == CH_RBRACE) begin
                     res_bus[n_res] = mk_res(EV_ENTRY_DONE, 8'h00, ERR_NONE);
                     n_res          = n_res + 2'd1;
                     phase_in       = PH_AFTER_ENT;
                  end else begin
                     res_bus[n_res] = mk_res(EV_ERROR, 8'h00, ERR_UNEXPECTED);
                     n_res          = n_res + 2'd1;
                     failed_in      = 1'b1;
                  end
               end
               PH_AFTER_ENT: begin
                  if (in_byte == CH_COMMA) begin
                     phase_in = PH_WANT_BRACE;
                  end else if (in_byte == CH_RBRACKET) begin
                     phase_in = PH_DONE;
                  end else begin
                     res_bus[n_res] = mk_res(EV_ERROR, 8'h00, ERR_UNEXPECTED);
                     n_res          = n_res + 2'd1;
                     failed_in      = 1'b1;
                  end
               end
               PH_DONE: begin
                  // trailing bytes are ignored
               end
               default: begin
               end
            endcase
         end

         // end-of-batch verdict
         if (in_final && !failed_in) begin
            if (phase_in == PH_IN_TAG || phase_in == PH_IN_VAL) begin
               res_bus[n_res] = mk_res(EV_ERROR, 8'h00, ERR_UNCLOSED);
            end else if (phase_in == PH_DONE) begin
               res_bus[n_res] = mk_res(EV_BATCH_OK, 8'h00, ERR_NONE);
            end else begin
               res_bus[n_res] = mk_res(EV_ERROR, 8'h00, ERR_NOT_CLOSED);
            end
            n_res = n_res + 2'd1;
         end
      end

      // final byte starts a new batch
      if (in_final) begin
         phase_in        = PH_START;
         quote_single_in = 1'b0;
         escape_in       = 1'b0;
         tag_len_in      = 4'd0;
         may_method_in   = 1'b1;
         may_url_in      = 1'b1;
         target_in       = TGT_NONE;
         url_first_in    = 1'b0;
         failed_in       = 1'b0;
      end
   end

   // bundle to the queue
   assign push_valid          = accept && (n_res != 2'd0);
   assign push_bundle.num_res = n_res;
   assign push_bundle.res     = res_bus;

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_START;
         quote_single_ff <= 1'b0;
         escape_ff       <= 1'b0;
         tag_len_ff      <= 4'd0;
         may_method_ff   <= 1'b1;
         may_url_ff      <= 1'b1;
         target_ff       <= TGT_NONE;
         url_first_ff    <= 1'b0;
         failed_ff       <= 1'b0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         quote_single_ff <= quote_single_in;
         escape_ff       <= escape_in;
         tag_len_ff      <= tag_len_in;
         may_method_ff   <= may_method_in;
         may_url_ff      <= may_url_in;
         target_ff       <= target_in;
         url_first_ff    <= url_first_in;
         failed_ff       <= failed_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bprl_queue.sv =====
// small bundle queue between parser front and output back
`default_nettype none

module bprl_queue
   import bprl_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push_valid,
   input  wire bprl_bundle_type push_bundle,
   input  wire logic            pop,
   output logic                 full,
   output logic                 empty,
   output bprl_bundle_type      head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bprl_bundle_type mem [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_bundle;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bprl_back.sv =====
// output back: unrolls bundles to one result per cycle unless stalled; output registered
`default_nettype none

module bprl_back
   import bprl_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            queue_empty,
   input  wire bprl_bundle_type head,
   output logic                 pop,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output bprl_result_type      out_res,
   output logic                 out_last
);

   logic            valid_ff, valid_in;
   bprl_result_type res_ff, res_in;
   logic            last_ff, last_in;
   logic [1:0]      idx_ff, idx_in;
   logic            load;
   logic            is_last;

   // queue not empty and output register free or draining this cycle
   assign load    = !queue_empty && (!valid_ff || out_ready);
   assign is_last = (idx_ff == (head.num_res - 2'd1));
   assign pop     = load && is_last;

   // next output item and bundle position
   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         res_in   = head.res[idx_ff];
         last_in  = is_last;
         idx_in   = is_last ? 2'd0 : idx_ff + 2'd1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      last_ff <= last_in;
   end

   // output control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_res   = res_ff;
   assign out_last  = last_ff;

endmodule

`default_nettype wire
